// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds at every edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// antecedent at one edge implies consequent at the next edge
`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/csed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csed_pkg
// shared widths, constants, types and helpers of the energy detector
// ----------------------------------------------------------------------------
package csed_pkg;

    localparam int WINDOW     = 480;
    localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_W      = $clog2(WINDOW + 1);
    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int ENERGY_W   = PTR_W + 31;
    localparam int E16_W      = ENERGY_W + 16;
    localparam int FLOOR_W    = 56;
    localparam int RATIO_W    = 8;
    localparam int FMIN_W     = 31;
    localparam int RISE_W     = 17;
    localparam int OUT_E_W    = 39;
    localparam int PROD_W     = FLOOR_W + RATIO_W;
    localparam int HIP_W      = FLOOR_W - 16 + RISE_W;
    localparam int LOP_W      = 16 + RISE_W;
    localparam int FMINP_W    = FMIN_W + WIN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [FLOOR_W-1:0] FLOOR_MAX = {FLOOR_W{1'b1}};
    localparam logic [63:0] FLOOR_RAW = 64'd1000000000 * 64'(WINDOW) * 64'd65536;
    localparam logic [FLOOR_W-1:0] FLOOR_RST =
        (FLOOR_RAW > 64'(FLOOR_MAX)) ? FLOOR_MAX : FLOOR_RAW[FLOOR_W-1:0];
    localparam logic [OUT_E_W-1:0] OUT_E_MAX = {OUT_E_W{1'b1}};

    localparam logic [RATIO_W-1:0] RATIO_RST = 8'd9;
    localparam logic [FMIN_W-1:0]  FMIN_RST  = 31'd25;
    localparam logic [RISE_W-1:0]  RISE_RST  = 17'd65569;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_SQ    = 2'd0,
        CFG_FLOOR_MIN   = 2'd1,
        CFG_RISE_FACTOR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_sq;
        logic [FMIN_W-1:0]  floor_min;
        logic [RISE_W-1:0]  rise_factor;
    } t_floor_cfg;

    typedef struct packed {
        logic               busy_res;
        logic [OUT_E_W-1:0] window_energy;
    } t_eval_res;

    function automatic logic [SQ_W-1:0] sq16(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] mag;
        mag = raw[SAMPLE_W-1] ? SAMPLE_W'({SAMPLE_W{1'b0}} - raw) : raw;
        return SQ_W'(mag) * SQ_W'(mag);
    endfunction

endpackage

// ===== hw/rtl/csed_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csed_ring
// sample ring in a single-port memory with the running sum of squares
// ----------------------------------------------------------------------------
module csed_ring (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [csed_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_busy,
    output logic [csed_pkg::ENERGY_W-1:0]        o_energy
);
    import csed_pkg::*;

    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [SAMPLE_W-1:0] r_new;
    logic [SQ_W-1:0]     r_sq_new;
    logic [PTR_W-1:0]    r_ptr;
    logic                r_phase;
    logic                r_full;
    logic [ENERGY_W-1:0] r_sum;
    logic [SQ_W-1:0]     sq_old;
    logic                last;

    // entries not yet written since reset read as zero
    assign sq_old = r_full ? sq16(r_rd_data) : '0;
    assign last   = (r_ptr == PTR_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd_data <= mem[r_ptr];
        end else if (r_phase) begin
            mem[r_ptr] <= r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_new    <= i_sample;
            r_sq_new <= sq16(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_ptr   <= '0;
            r_full  <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_phase <= i_start;
            if (r_phase) begin
                r_sum <= r_sum + ENERGY_W'(r_sq_new) - ENERGY_W'(sq_old);
                if (last) begin
                    r_ptr  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + PTR_W'(1);
                end
            end
        end
    end

    assign o_busy   = r_phase;
    assign o_energy = r_sum;

endmodule

// ===== hw/rtl/csed_floor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csed_floor
// noise floor tracking and busy decision, one evaluation at a time
// ----------------------------------------------------------------------------
module csed_floor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [csed_pkg::ENERGY_W-1:0] i_energy,
    input  csed_pkg::t_floor_cfg          i_cfg,
    output logic                          o_busy,
    output logic                          o_done,
    output csed_pkg::t_eval_res           o_res
);
    import csed_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_RAT,
        S_CMP
    } t_state;

    t_state              r_state;
    logic [FLOOR_W-1:0]  r_floor;
    logic [E16_W-1:0]    r_e16;
    logic [OUT_E_W-1:0]  r_e_out;
    logic                r_drop;
    logic [HIP_W-1:0]    r_hi_p;
    logic [LOP_W-1:0]    r_lo_p;
    logic [FMINP_W-1:0]  r_fmin_p;
    logic [PROD_W-1:0]   r_rp;
    logic [63:0]         rise_sum;
    logic [63:0]         fmin_sh;
    logic [FLOOR_W-1:0]  rise_sat;
    logic [FLOOR_W-1:0]  fmin_sat;
    logic [FLOOR_W-1:0]  cand;
    logic [FLOOR_W-1:0]  n_floor;

    always_comb begin
        rise_sum = 64'(r_hi_p) + 64'(r_lo_p[LOP_W-1:16]);
        rise_sat = (rise_sum > 64'(FLOOR_MAX)) ? FLOOR_MAX : rise_sum[FLOOR_W-1:0];
        fmin_sh  = 64'(r_fmin_p) << 16;
        fmin_sat = (fmin_sh > 64'(FLOOR_MAX)) ? FLOOR_MAX : fmin_sh[FLOOR_W-1:0];
        cand     = r_drop ? FLOOR_W'(r_e16) : rise_sat;
        n_floor  = (cand < fmin_sat) ? fmin_sat : cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_floor <= FLOOR_RST;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_e16   <= {i_energy, 16'd0};
                        r_e_out <= (64'(i_energy) > 64'(OUT_E_MAX)) ? OUT_E_MAX
                                                                    : OUT_E_W'(i_energy);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_drop   <= (64'(r_e16) < 64'(r_floor));
                    r_hi_p   <= HIP_W'(r_floor[FLOOR_W-1:16]) * HIP_W'(i_cfg.rise_factor);
                    r_lo_p   <= LOP_W'(r_floor[15:0]) * LOP_W'(i_cfg.rise_factor);
                    r_fmin_p <= FMINP_W'(i_cfg.floor_min) * FMINP_W'(WINDOW);
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    r_floor <= n_floor;
                    r_state <= S_RAT;
                end
                S_RAT: begin
                    r_rp    <= PROD_W'(i_cfg.ratio_sq) * PROD_W'(r_floor);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_done              = (r_state == S_CMP);
    assign o_res.busy_res      = (PROD_W'(r_e16) > r_rp);
    assign o_res.window_energy = r_e_out;

endmodule

// ===== hw/rtl/carrier_sense_energy_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carrier_sense_energy_detector
// sliding-window energy against a tracked noise floor for 16-bit audio
// ----------------------------------------------------------------------------
// A sample item (func 0) uses the 480-entry sample ring, which sits in one
// single-port memory that is read when the item is taken and then written
// back while the sum of squares is updated. Sample items give no result.
// An evaluate item (func 1) passes through the floor update chain (floor
// products, floor select and minimum, ratio product, compare) and leaves
// one result in the output register, where it waits while further sample
// items are taken. While neither the ring nor the floor chain is busy, an
// evaluate item is held off only while a previous result is still waiting
// and stalled. After reset the ring reads as all zero until it has been
// filled once; there is no clearing pass. Configuration writes are taken at
// any cycle and are meant to be made while the block is idle.
module carrier_sense_energy_detector (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [csed_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [csed_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_func,
    input  logic signed [csed_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_busy_res,
    output logic [csed_pkg::OUT_E_W-1:0]           o_window_energy
);
    import csed_pkg::*;

`include "assert_macros.svh"

    logic [RATIO_W-1:0]  r_ratio_sq;
    logic [FMIN_W-1:0]   r_floor_min;
    logic [RISE_W-1:0]   r_rise_factor;
    logic                r_out_valid;
    logic                r_busy_res;
    logic [OUT_E_W-1:0]  r_window_energy;
    t_floor_cfg          floor_cfg;
    t_eval_res           eval_res;
    logic                ring_busy;
    logic                floor_busy;
    logic                floor_done;
    logic [ENERGY_W-1:0] energy;
    logic                in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_sq    <= RATIO_RST;
            r_floor_min   <= FMIN_RST;
            r_rise_factor <= RISE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_RATIO_SQ:    r_ratio_sq    <= i_cfg_wdata[RATIO_W-1:0];
                CFG_FLOOR_MIN:   r_floor_min   <= i_cfg_wdata[FMIN_W-1:0];
                CFG_RISE_FACTOR: r_rise_factor <= i_cfg_wdata[RISE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign floor_cfg.ratio_sq    = r_ratio_sq;
    assign floor_cfg.floor_min   = r_floor_min;
    assign floor_cfg.rise_factor = r_rise_factor;

    // an evaluate item needs the output register free by the time it finishes
    assign o_in_stall = ring_busy | floor_busy | (i_func & r_out_valid & i_out_stall);
    assign in_acc     = i_in_valid & ~o_in_stall;

    csed_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc & ~i_func),
        .i_sample (i_sample),
        .o_busy   (ring_busy),
        .o_energy (energy)
    );

    csed_floor u_floor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc & i_func),
        .i_energy (energy),
        .i_cfg    (floor_cfg),
        .o_busy   (floor_busy),
        .o_done   (floor_done),
        .o_res    (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (floor_done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (floor_done) begin
            r_busy_res      <= eval_res.busy_res;
            r_window_energy <= eval_res.window_energy;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_busy_res      = r_busy_res;
    assign o_window_energy = r_window_energy;

    `ASSERT_ALWAYS(a_one_engine, i_clk, i_rst_n, !(ring_busy && floor_busy))
    `ASSERT_ALWAYS(a_out_free, i_clk, i_rst_n, !(floor_done && r_out_valid && i_out_stall))
    `ASSERT_IMPLY_NEXT(a_smp_start, i_clk, i_rst_n, in_acc && !i_func, ring_busy)
    `ASSERT_IMPLY_NEXT(a_eval_start, i_clk, i_rst_n, in_acc && i_func, floor_busy)

endmodule
